@@ hw/rtl/pvl_pkg.sv @@
// ----------------------------------------------------------------------------
// pvl_pkg
// Shared types and constants for the pot voltage to light level block.
// ----------------------------------------------------------------------------
package pvl_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_TOLERANCE = 2'd0;
  localparam logic [1:0] CFG_NEEDED    = 2'd1;
  localparam logic [1:0] CFG_WINDOW    = 2'd2;

  // configuration reset values
  localparam logic [11:0] TOLERANCE_RST = 12'd20;
  localparam logic [7:0]  NEEDED_RST    = 8'd5;
  localparam logic [7:0]  WINDOW_RST    = 8'd8;

  // arithmetic constants
  localparam logic [11:0] VOLT_CAP      = 12'd3230;
  localparam logic [11:0] VOLT_CAP_P1   = 12'd3231;
  localparam logic [9:0]  RES_SCALE     = 10'd1000;
  localparam logic [14:0] FULL_RES      = 15'd20000;
  localparam logic [15:0] LEVEL_SCALE   = 16'hFFFF;
  localparam logic [7:0]  LEVEL_MAX     = 8'd254;

  // divider runs, two quotient bits per cycle
  localparam int unsigned CNT_W = 4;
  localparam logic [CNT_W-1:0] AVG_DIV_CYCLES   = 4'd10;  // 20 quotient bits
  localparam logic [CNT_W-1:0] RES_DIV_CYCLES   = 4'd11;  // 22 quotient bits
  localparam logic [CNT_W-1:0] SCALE_DIV_CYCLES = 4'd8;   // 16 quotient bits
  localparam logic [CNT_W-1:0] SQRT_CYCLES      = 4'd4;   // 8 root bits

  typedef enum logic [1:0] {
    DIV_AVG,
    DIV_RES,
    DIV_SCALE
  } pvl_div_op_e;

  typedef struct packed {
    logic        load_in;
    logic        eval;
    logic        div_load;
    pvl_div_op_e div_op;
    logic        div_step;
    logic        cap_avg;
    logic        sqrt_load;
    logic        sqrt_step;
    logic        decide;
    logic        emit;
  } pvl_cmd_t;

  typedef struct packed {
    logic avg_due;
  } pvl_sts_t;

endpackage

@@ hw/rtl/pot_voltage_to_light_level.sv @@
// ----------------------------------------------------------------------------
// pot_voltage_to_light_level
// Turns divider millivolt samples into light level updates, one word each.
// ----------------------------------------------------------------------------
// Each input word (sample_mv, current_level) yields exactly one output word.
// A sample that only refreshes the run count is emitted directly; the
// sample that closes an averaging window first runs the shared divider, at
// two quotient bits a cycle, for the average, the resistance and the level
// scaling, and then the square root. One word is in flight at a time; the
// output register lets the next word be accepted while a finished result
// waits for the sink. Configuration (index 0 tolerance_mv, 1 samples_needed,
// 2 averaging window) is always ready; the user must write it only while
// the block is idle, which the block itself does not enforce. Every
// REFRESH_PERIOD samples the accepted voltage drops to zero.
// ----------------------------------------------------------------------------
module pot_voltage_to_light_level import pvl_pkg::*; #(
  parameter int unsigned REFRESH_PERIOD = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write port
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [11:0]       cfg_data_i,
  // input words
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [11:0]       sample_mv_i,
  input  logic signed [8:0] current_level_i,
  // output words
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              level_changed_o,
  output logic [7:0]        new_level_o
);

  pvl_cmd_t cmd;
  pvl_sts_t sts;

  // registers take a write on any cycle
  assign cfg_ready_o = 1'b1;

  // sequencer: handshakes and step order
  pvl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: state, divider, root unit, output register
  pvl_dp #(
    .REFRESH_PERIOD (REFRESH_PERIOD)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .sample_mv_i     (sample_mv_i),
    .current_level_i (current_level_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .level_changed_o (level_changed_o),
    .new_level_o     (new_level_o)
  );

endmodule

@@ hw/rtl/pvl_ctrl.sv @@
// ----------------------------------------------------------------------------
// pvl_ctrl
// Sequencer: steps one word through update, divisions, root and decision.
// ----------------------------------------------------------------------------
module pvl_ctrl import pvl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  pvl_sts_t sts_i,
  output pvl_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_AVG_LD,
    S_AVG_RUN,
    S_CAP,
    S_RES_LD,
    S_RES_RUN,
    S_SCL_LD,
    S_SCL_RUN,
    S_SQ_LD,
    S_SQ_RUN,
    S_DECIDE,
    S_EMIT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             last_step;

  assign last_step   = (cnt_q == CNT_W'(1));
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.div_op = DIV_AVG;
    unique case (state_q) inside
      S_IDLE:    cmd_o.load_in = in_valid_i;
      S_EVAL:    cmd_o.eval = 1'b1;
      S_AVG_LD: begin
        cmd_o.div_load = 1'b1;
        cmd_o.div_op   = DIV_AVG;
      end
      S_RES_LD: begin
        cmd_o.div_load = 1'b1;
        cmd_o.div_op   = DIV_RES;
      end
      S_SCL_LD: begin
        cmd_o.div_load = 1'b1;
        cmd_o.div_op   = DIV_SCALE;
      end
      S_AVG_RUN, S_RES_RUN, S_SCL_RUN: cmd_o.div_step = 1'b1;
      S_CAP:     cmd_o.cap_avg = 1'b1;
      S_SQ_LD:   cmd_o.sqrt_load = 1'b1;
      S_SQ_RUN:  cmd_o.sqrt_step = 1'b1;
      S_DECIDE:  cmd_o.decide = 1'b1;
      S_EMIT:    cmd_o.emit = !out_valid_q || !out_stall_i;
      default:   cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EVAL;
        end
        S_EVAL: begin
          state_q <= sts_i.avg_due ? S_AVG_LD : S_EMIT;
        end
        S_AVG_LD: begin
          cnt_q   <= AVG_DIV_CYCLES;
          state_q <= S_AVG_RUN;
        end
        S_AVG_RUN: begin
          cnt_q <= cnt_q - 1'b1;
          if (last_step) state_q <= S_CAP;
        end
        S_CAP: begin
          state_q <= S_RES_LD;
        end
        S_RES_LD: begin
          cnt_q   <= RES_DIV_CYCLES;
          state_q <= S_RES_RUN;
        end
        S_RES_RUN: begin
          cnt_q <= cnt_q - 1'b1;
          if (last_step) state_q <= S_SCL_LD;
        end
        S_SCL_LD: begin
          cnt_q   <= SCALE_DIV_CYCLES;
          state_q <= S_SCL_RUN;
        end
        S_SCL_RUN: begin
          cnt_q <= cnt_q - 1'b1;
          if (last_step) state_q <= S_SQ_LD;
        end
        S_SQ_LD: begin
          cnt_q   <= SQRT_CYCLES;
          state_q <= S_SQ_RUN;
        end
        S_SQ_RUN: begin
          cnt_q <= cnt_q - 1'b1;
          if (last_step) state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (cmd_o.emit) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/pvl_dp.sv @@
// ----------------------------------------------------------------------------
// pvl_dp
// Datapath: config, run/average state, shared divider, root unit, result.
// ----------------------------------------------------------------------------
module pvl_dp import pvl_pkg::*; #(
  parameter int unsigned REFRESH_PERIOD = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [11:0]       cfg_data_i,
  input  logic [11:0]       sample_mv_i,
  input  logic signed [8:0] current_level_i,
  input  pvl_cmd_t          cmd_i,
  output pvl_sts_t          sts_o,
  output logic              level_changed_o,
  output logic [7:0]        new_level_o
);

  localparam int unsigned TICK_W = $clog2(REFRESH_PERIOD);
  localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(REFRESH_PERIOD - 1);

  typedef enum logic [1:0] {
    DIR_DOWN  = 2'd0,
    DIR_UP    = 2'd1,
    DIR_UNDEF = 2'd2
  } dir_e;

  // config
  logic [11:0] tol_q;
  logic [7:0]  needed_q, window_q;

  // item and running state
  logic [11:0]       sample_q;
  logic signed [8:0] cur_q;
  logic [11:0]       accepted_q;
  logic [7:0]        last_lvl_q;
  dir_e              dir_q;
  logic signed [9:0] count_q;
  logic [19:0]       sum_q;
  logic [TICK_W-1:0] tick_q;

  // shared divider and root unit
  logic [14:0] rem_q, dvs_q;
  logic [21:0] dvd_q, quo_q;
  logic [11:0] avg_q;
  logic [15:0] sq_x_q;
  logic [9:0]  sq_rem_q;
  logic [7:0]  sq_root_q;

  // result and output word
  logic       res_changed_q, out_changed_q;
  logic [7:0] res_level_q, out_level_q;

  // ---- per-sample update ----
  logic              refresh, quiet, averaging, avg_due;
  logic [11:0]       acc_eff, mag;
  logic [12:0]       diff, diff_neg;
  logic signed [9:0] cnt_inc, cnt_run, needed_s, window_s;
  logic [19:0]       sum_add;

  always_comb begin
    refresh   = (tick_q == TICK_LAST);
    acc_eff   = refresh ? '0 : accepted_q;
    diff      = {1'b0, sample_q} - {1'b0, acc_eff};
    diff_neg  = -diff;
    mag       = diff[12] ? diff_neg[11:0] : diff[11:0];
    quiet     = (mag < tol_q);
    needed_s  = signed'({2'b00, needed_q});
    window_s  = signed'({2'b00, window_q});
    cnt_inc   = count_q + 10'sd1;
    cnt_run   = (cnt_inc >= needed_s) ? -window_s : cnt_inc;
    averaging = (cnt_run < 10'sd0);
    avg_due   = !quiet && (cnt_run == -10'sd1);
    sum_add   = sum_q + 20'(sample_q);
  end

  assign sts_o.avg_due = avg_due;

  // ---- divider operands and steps ----
  logic [14:0] r_cap;
  logic [21:0] res_num;
  logic [30:0] scl_num;
  logic [14:0] st_rem;
  logic [21:0] st_dvd, st_quo;
  logic [15:0] st_part;

  always_comb begin
    r_cap   = (quo_q > 22'(FULL_RES)) ? FULL_RES : quo_q[14:0];
    res_num = 22'(avg_q) * 22'(RES_SCALE);
    scl_num = 31'(r_cap) * 31'(LEVEL_SCALE);
    st_rem  = rem_q;
    st_dvd  = dvd_q;
    st_quo  = quo_q;
    for (int i = 0; i < 2; i++) begin
      st_part = {st_rem, st_dvd[21]};
      st_dvd  = {st_dvd[20:0], 1'b0};
      if (st_part >= {1'b0, dvs_q}) begin
        st_rem = 15'(st_part - {1'b0, dvs_q});
        st_quo = {st_quo[20:0], 1'b1};
      end else begin
        st_rem = st_part[14:0];
        st_quo = {st_quo[20:0], 1'b0};
      end
    end
  end

  // ---- square root, two root bits per cycle ----
  logic [15:0] sq_x;
  logic [9:0]  sq_rem;
  logic [7:0]  sq_root;
  logic [11:0] sq_t, sq_tr;

  always_comb begin
    sq_x    = sq_x_q;
    sq_rem  = sq_rem_q;
    sq_root = sq_root_q;
    for (int i = 0; i < 2; i++) begin
      sq_t  = {sq_rem, sq_x[15:14]};
      sq_tr = {2'b00, sq_root, 2'b01};
      sq_x  = {sq_x[13:0], 2'b00};
      if (sq_t >= sq_tr) begin
        sq_rem  = 10'(sq_t - sq_tr);
        sq_root = {sq_root[6:0], 1'b1};
      end else begin
        sq_rem  = sq_t[9:0];
        sq_root = {sq_root[6:0], 1'b0};
      end
    end
  end

  // ---- decision ----
  logic [7:0]        lvl;
  logic signed [9:0] lvl_s, cur_s;
  logic              capped, follows, unknown, up, flip, issue;

  always_comb begin
    lvl     = (sq_root_q > LEVEL_MAX) ? LEVEL_MAX : sq_root_q;
    lvl_s   = signed'({2'b00, lvl});
    cur_s   = 10'(cur_q);
    capped  = (avg_q == VOLT_CAP);
    follows = (cur_s == signed'({2'b00, last_lvl_q}));
    unknown = (cur_s == -10'sd1);
    up      = (lvl_s > cur_s);
    flip    = ((dir_q == DIR_DOWN) && up) || ((dir_q == DIR_UP) && !up);
    issue   = (follows || unknown || flip) && (lvl_s != cur_s) && !capped;
  end

  // ---- control state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q      <= TOLERANCE_RST;
      needed_q   <= NEEDED_RST;
      window_q   <= WINDOW_RST;
      accepted_q <= '0;
      last_lvl_q <= '0;
      dir_q      <= DIR_UNDEF;
      count_q    <= '0;
      sum_q      <= '0;
      tick_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_TOLERANCE: tol_q    <= cfg_data_i;
          CFG_NEEDED:    needed_q <= cfg_data_i[7:0];
          CFG_WINDOW:    window_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end

      if (cmd_i.eval) begin
        tick_q     <= refresh ? '0 : tick_q + 1'b1;
        accepted_q <= acc_eff;
        if (quiet) begin
          count_q <= '0;
          sum_q   <= '0;
          dir_q   <= DIR_UNDEF;
        end else begin
          count_q <= cnt_run;
          if (averaging) sum_q <= sum_add;
        end
      end

      if (cmd_i.decide) begin
        accepted_q <= avg_q;
        count_q    <= '0;
        sum_q      <= '0;
        if (issue) begin
          last_lvl_q <= lvl;
          dir_q      <= DIR_UNDEF;
        end else if (!(follows || unknown || flip)) begin
          dir_q <= up ? DIR_UP : DIR_DOWN;
        end
      end
    end
  end

  // ---- payload ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sample_q <= sample_mv_i;
      cur_q    <= current_level_i;
    end

    if (cmd_i.div_load) begin
      quo_q <= '0;
      unique case (cmd_i.div_op)
        DIV_AVG: begin
          rem_q <= '0;
          dvd_q <= {sum_q, 2'b00};
          dvs_q <= 15'(window_q);
        end
        DIV_RES: begin
          rem_q <= '0;
          dvd_q <= res_num;
          dvs_q <= 15'(VOLT_CAP_P1 - avg_q);
        end
        DIV_SCALE: begin
          rem_q <= scl_num[30:16];
          dvd_q <= {scl_num[15:0], 6'b000000};
          dvs_q <= FULL_RES;
        end
        default: begin
          rem_q <= '0;
          dvd_q <= '0;
          dvs_q <= FULL_RES;
        end
      endcase
    end else if (cmd_i.div_step) begin
      rem_q <= st_rem;
      dvd_q <= st_dvd;
      quo_q <= st_quo;
    end

    if (cmd_i.cap_avg) begin
      avg_q <= (quo_q >= 22'(VOLT_CAP)) ? VOLT_CAP : quo_q[11:0];
    end

    if (cmd_i.sqrt_load) begin
      sq_x_q    <= quo_q[15:0];
      sq_rem_q  <= '0;
      sq_root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      sq_x_q    <= sq_x;
      sq_rem_q  <= sq_rem;
      sq_root_q <= sq_root;
    end

    if (cmd_i.eval) begin
      res_changed_q <= 1'b0;
      res_level_q   <= '0;
    end else if (cmd_i.decide) begin
      res_changed_q <= issue;
      res_level_q   <= issue ? lvl : 8'd0;
    end

    if (cmd_i.emit) begin
      out_changed_q <= res_changed_q;
      out_level_q   <= res_level_q;
    end
  end

  assign level_changed_o = out_changed_q;
  assign new_level_o     = out_level_q;

endmodule

@@ bench/pvl_level_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pvl_level_checker
// Tracks the divider state from the words the block accepts and checks every
// output word against the level it should carry.
// ----------------------------------------------------------------------------
module pvl_level_checker import pvl_pkg::*; #(
  parameter int unsigned REFRESH_PERIOD = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [11:0]       cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [11:0]       sample_mv_i,
  input  logic signed [8:0] current_level_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic              level_changed_i,
  input  logic [7:0]        new_level_i,
  output int                pending_o,
  output int                fail_count_o
);

  typedef enum logic [1:0] {
    SWEEP_DOWN    = 2'd0,
    SWEEP_UP      = 2'd1,
    SWEEP_UNKNOWN = 2'd2
  } sweep_dir_e;

  typedef struct packed {
    logic       changed;
    logic [7:0] level;
  } level_word_t;

  localparam int PERIOD    = REFRESH_PERIOD;
  localparam int MV_CAP    = VOLT_CAP;
  localparam int OHM_SCALE = RES_SCALE;
  localparam int OHM_FULL  = FULL_RES;
  localparam int LVL_SCALE = LEVEL_SCALE;
  localparam int LVL_TOP   = LEVEL_MAX;

  // shadow registers and divider state
  int          tol_mv;
  int          needed;
  int          window;
  int          accepted_mv;
  int          last_level;
  sweep_dir_e  sweep;
  int          run_count;    // negative while a window is being summed
  int          mv_sum;
  int          ticks;
  int          err_n;
  level_word_t levels_q[$];

  function automatic int floor_root(input int v);
    int root;
    root = 0;
    for (int b = 8; b >= 0; b--) begin
      int t;
      t = root | (1 << b);
      if (t * t <= v) root = t;
    end
    return root;
  endfunction

  function automatic int level_of_mv(input int avg);
    int ohms;
    int root;
    ohms = (avg * OHM_SCALE) / (MV_CAP + 1 - avg);
    if (ohms > OHM_FULL) ohms = OHM_FULL;
    root = floor_root((ohms * LVL_SCALE) / OHM_FULL);
    return (root > LVL_TOP) ? LVL_TOP : root;
  endfunction

  task automatic track_sample(input logic [11:0] mv, input logic signed [8:0] lvl_in,
                              output level_word_t w);
    int         cur;
    int         smp;
    int         gap_mv;
    int         avg;
    int         lvl;
    bit         update;
    sweep_dir_e dir;
    w      = '0;
    cur    = int'(lvl_in);
    smp    = int'(mv);
    update = 1'b0;

    ticks = ticks + 1;
    if (ticks >= PERIOD) begin
      ticks       = 0;
      accepted_mv = 0;
    end

    gap_mv = smp - accepted_mv;
    if (gap_mv < 0) gap_mv = -gap_mv;

    if (gap_mv < tol_mv) begin
      // unchanged sample: start over
      run_count = 0;
      mv_sum    = 0;
      sweep     = SWEEP_UNKNOWN;
    end else begin
      run_count = run_count + 1;
      if (run_count >= needed) run_count = -window;
      if (run_count < 0) begin
        mv_sum = mv_sum + smp;
        if (run_count == -1) begin
          avg = mv_sum / window;
          if (avg > MV_CAP) avg = MV_CAP;
          lvl = level_of_mv(avg);
          if (last_level == cur || cur == -1) begin
            update = 1'b1;
          end else begin
            // foreign level: only follow once the sweep turns round
            dir = (lvl > cur) ? SWEEP_UP : SWEEP_DOWN;
            if ((sweep == SWEEP_DOWN && dir == SWEEP_UP) ||
                (sweep == SWEEP_UP && dir == SWEEP_DOWN)) begin
              update = 1'b1;
            end else begin
              sweep = dir;
            end
          end
          if (update && lvl != cur && avg < MV_CAP) begin
            w.changed  = 1'b1;
            w.level    = lvl[7:0];
            last_level = lvl;
            sweep      = SWEEP_UNKNOWN;
          end
          accepted_mv = avg;
          run_count   = 0;
          mv_sum      = 0;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    level_word_t got;
    level_word_t want;
    if (!rst_ni) begin
      tol_mv       = int'(TOLERANCE_RST);
      needed       = int'(NEEDED_RST);
      window       = int'(WINDOW_RST);
      accepted_mv  = 0;
      last_level   = 0;
      sweep        = SWEEP_UNKNOWN;
      run_count    = 0;
      mv_sum       = 0;
      ticks        = 0;
      err_n        = 0;
      levels_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // results first: a word accepted on this edge cannot answer itself
      if (out_valid_i && !out_stall_i) begin
        got = {level_changed_i, new_level_i};
        if (levels_q.size() == 0) begin
          $error("output word with none pending: level_changed %0d new_level %0d",
                 got.changed, got.level);
          err_n = err_n + 1;
        end else begin
          want = levels_q.pop_front();
          if (got.changed !== want.changed) begin
            $error("level_changed: expected %0d, got %0d", want.changed, got.changed);
            err_n = err_n + 1;
          end
          if (got.level !== want.level) begin
            $error("new_level: expected %0d, got %0d", want.level, got.level);
            err_n = err_n + 1;
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TOLERANCE: tol_mv = int'(cfg_data_i);
          CFG_NEEDED:    needed = int'(cfg_data_i[7:0]);
          CFG_WINDOW:    window = int'(cfg_data_i[7:0]);
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        track_sample(sample_mv_i, current_level_i, want);
        levels_q.push_back(want);
      end

      pending_o    <= levels_q.size();
      fail_count_o <= err_n;
    end
  end

endmodule

@@ bench/tb_pot_voltage_to_light_level.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pot_voltage_to_light_level
// Drives divider samples and register settings into the light level block
// and leaves prediction and comparison to pvl_level_checker.
// ----------------------------------------------------------------------------
// A short directed run hits the cap, an unchanged sample, a foreign level
// below and above range, a sweep that turns round and a repeated level. The
// rest is phases under fixed register settings (defaults, zero tolerance and
// run, full tolerance, no window, longest run, widest window, random ones),
// each made mostly of sweeps: runs of samples held near a target, long
// enough to close one window, with the level in force fed back from issued
// words. Holds and noise words are mixed in. The refresh period is shortened
// so the forced zero of the accepted voltage comes round several times.
// ----------------------------------------------------------------------------
module tb_pot_voltage_to_light_level;
  import pvl_pkg::*;

  localparam int REFRESH     = 320;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [1:0] CFG_UNUSED = 2'd3;  // index the block ignores

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = CFG_TOLERANCE;
  logic [11:0]       cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [11:0]       sample_mv = '0;
  logic signed [8:0] current_level = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              level_changed;
  logic [7:0]        new_level;
  int                pending;
  int                fail_count;

  // stimulus bookkeeping
  int tol_cur;
  int need_cur;
  int win_cur;
  int items_left;
  int last_target = 0;
  int level_in_force = -1;  // what the lamp shows, as seen from issued words
  int rx_wait = 0;
  int cycle_cnt = 0;
  bit idle_on = 1'b1;
  bit bus_held = 1'b0;      // input valid still high from the last word

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pot_voltage_to_light_level #(
    .REFRESH_PERIOD (REFRESH)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .sample_mv_i     (sample_mv),
    .current_level_i (current_level),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .level_changed_o (level_changed),
    .new_level_o     (new_level)
  );

  pvl_level_checker #(
    .REFRESH_PERIOD (REFRESH)
  ) i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .sample_mv_i     (sample_mv),
    .current_level_i (current_level),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .level_changed_i (level_changed),
    .new_level_i     (new_level),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_pot_voltage_to_light_level failed");
      $finish;
    end
  end

  // sink: after each taken word, a random draw (only while idle_on) may raise stall for the next
  always @(posedge clk or negedge rst_n) begin : sink
    int n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
    end else if (out_valid && !out_stall) begin
      n = idle_on ? $urandom_range(0, 4) : 0;
      rx_wait   <= n;
      out_stall <= (n != 0);
    end else if (out_valid && out_stall) begin
      if (rx_wait > 1) begin
        rx_wait <= rx_wait - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // the level in force follows what the block issues
  always @(posedge clk) begin
    if (out_valid && !out_stall && level_changed) level_in_force <= int'(new_level);
  end

  function automatic int clip_mv(input int v);
    return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
  endfunction

  task automatic release_bus();
    if (bus_held) begin
      in_valid <= 1'b0;
      bus_held = 1'b0;
    end
  endtask

  // waits on the clock even when nothing is pending, so valid is seen low before it rises
  task automatic settle_idle();
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_word(input int mv, input int lvl);
    int gap;
    // now and then hold off until the block has answered everything
    if ($urandom_range(0, 99) == 0) begin
      release_bus();
      settle_idle();
    end
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      release_bus();
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    sample_mv     <= mv[11:0];
    current_level <= lvl[8:0];
    do @(posedge clk); while (in_stall);
    bus_held   = 1'b1;
    items_left = items_left - 1;
  endtask

  // register writes back to back; the unused index and the spare data bits
  // of the 8-bit registers carry junk when asked
  task automatic write_cfg(input int tol, input int need, input int win, input bit junk);
    logic [1:0]  idx[4];
    logic [11:0] val[4];
    logic [3:0]  pad_n;
    logic [3:0]  pad_w;
    int          first;
    pad_n  = junk ? 4'($urandom_range(0, 15)) : 4'h0;
    pad_w  = junk ? 4'($urandom_range(0, 15)) : 4'h0;
    idx[0] = CFG_UNUSED;    val[0] = 12'($urandom_range(0, 4095));
    idx[1] = CFG_TOLERANCE; val[1] = tol[11:0];
    idx[2] = CFG_NEEDED;    val[2] = {pad_n, need[7:0]};
    idx[3] = CFG_WINDOW;    val[3] = {pad_w, win[7:0]};
    first  = junk ? 0 : 1;
    for (int i = first; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    tol_cur  = tol;
    need_cur = need;
    win_cur  = win;
  endtask

  // run of samples near one target, sized to close a window from a clean run
  task automatic play_sweep();
    int pick;
    int target;
    int n;
    int mode;
    int foreign;
    int jit;
    int lvl;
    pick = $urandom_range(0, 9);
    case (pick)
      0: target = $urandom_range(0, 40);
      1: target = $urandom_range(3200, 4095);
      2: begin
        jit    = tol_cur + $urandom_range(0, 30);
        target = clip_mv($urandom_range(0, 1) ? last_target + jit : last_target - jit);
      end
      default: target = $urandom_range(0, 4095);
    endcase
    n = need_cur + win_cur + (($urandom_range(0, 3) == 0) ? 1 : 0);
    if (n == 0) n = 1;
    mode    = $urandom_range(0, 9);
    foreign = $urandom_range(0, 254);
    while (n > 0 && items_left > 0) begin
      jit = $urandom_range(0, 4);
      if (mode < 6) lvl = level_in_force;
      else if (mode == 6) lvl = -1;
      else if (mode < 9) lvl = foreign;
      else lvl = $urandom_range(0, 511);
      send_word(clip_mv(target + jit - 2), lvl);
      n = n - 1;
    end
    last_target = target;
  endtask

  // a few samples back at the last target, mostly inside tolerance
  task automatic play_hold();
    int n;
    int jit;
    n = $urandom_range(1, 3);
    while (n > 0 && items_left > 0) begin
      jit = $urandom_range(0, 2);
      send_word(clip_mv(last_target + jit - 1), level_in_force);
      n = n - 1;
    end
  endtask

  task automatic play_noise();
    int n;
    n = $urandom_range(1, 6);
    while (n > 0 && items_left > 0) begin
      send_word($urandom_range(0, 4095), $urandom_range(0, 511));
      n = n - 1;
    end
  endtask

  task automatic run_phase(input int tol, input int need, input int win, input bit junk,
                           input int budget, input bit idle);
    int k;
    release_bus();
    settle_idle();
    write_cfg(tol, need, win, junk);
    idle_on    = idle;
    items_left = budget;
    while (items_left > 0) begin
      k = $urandom_range(0, 19);
      if (k < 14) play_sweep();
      else if (k < 17) play_hold();
      else play_noise();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one differing sample opens a two-sample window
    write_cfg(20, 1, 2, 1'b0);
    idle_on = 1'b1;
    repeat (2) send_word(4095, -1);    // average above the cap, nothing issued
    send_word(3229, -1);               // within tolerance of the capped value
    repeat (2) send_word(0, 255);      // level out of range, sweep goes down
    repeat (2) send_word(2000, -256);  // turns round, so the update goes out
    repeat (2) send_word(1000, 72);    // level in force is our own
    repeat (2) send_word(1025, 38);    // works out to the level already shown
    repeat (2) send_word(3230, 38);    // exactly at the cap
    repeat (2) send_word(4095, 0);

    run_phase(int'(TOLERANCE_RST), int'(NEEDED_RST), int'(WINDOW_RST), 1'b0, 200, 1'b1);
    run_phase(0, 0, 1, 1'b0, 120, 1'b0);     // no tolerance, no run needed
    run_phase(4095, 1, 1, 1'b0, 40, 1'b1);   // nearly everything is unchanged
    run_phase(10, 3, 0, 1'b1, 60, 1'b1);     // no window, never averages
    run_phase(1, 255, 2, 1'b1, 280, 1'b1);   // longest run before averaging
    run_phase(5, 1, 255, 1'b0, 270, 1'b1);   // widest window
    repeat (3) begin
      run_phase($urandom_range(0, 200), $urandom_range(1, 8), $urandom_range(1, 8),
                1'b1, 60, 1'($urandom_range(0, 1)));
    end

    release_bus();
    settle_idle();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_pot_voltage_to_light_level passed");
    end else begin
      $display("tb_pot_voltage_to_light_level failed");
    end
    $finish;
  end

endmodule
